/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the radix text converter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is low
`define SIRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define SIRT_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    `SIRT_ASSERT(lbl, clk, rst_n, (pre) |-> (post), msg)

`endif

/* rtl/sirt_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the radix text converter
package sirt_pkg;

    // Sizes
    localparam int MAX_SYMBOLS = 64;
    localparam int VALUE_BITS  = 32;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 7;
    localparam int SYM_AW      = $clog2(MAX_SYMBOLS);
    localparam int DIGIT_W     = SYM_AW;
    localparam int STACK_AW    = $clog2(VALUE_BITS);
    localparam int SP_W        = $clog2(VALUE_BITS + 1);
    localparam int SEEN_W      = 1 << CHAR_W;

    // Divider: quotient bits produced per cycle and cycles per digit
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = VALUE_BITS / DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(10);

    // Command codes of an input word
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // Characters
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    typedef logic [CHAR_W-1:0]     char_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [SYM_AW-1:0]     sym_idx_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic start;
        logic check_en;
        logic div_en;
        logic sign_load;
        logic pop;
        logic fetch;
        logic show_load;
    } sirt_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic range_ok;
        logic chk_done;
        logic base_ok;
        logic digit_done;
        logic quot_zero;
        logic neg;
        logic sp_zero;
        logic out_free;
    } sirt_stat_t;

    // Whitespace and sign characters may not serve as digit symbols
    function automatic logic bad_symbol(input char_t c);
        return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_FF) ||
               (c == CH_CR) || (c == CH_SPACE) || (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

endpackage

/* rtl/sirt_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the radix text converter
interface sirt_req_if;
    import sirt_pkg::*;

    logic          valid;
    logic          ready;
    logic          cmd;
    sym_idx_t      symbol_index;
    char_t         symbol_byte;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, cmd, symbol_index, symbol_byte, value, input ready);
    modport sink   (input valid, cmd, symbol_index, symbol_byte, value, output ready);
endinterface

interface sirt_rsp_if;
    import sirt_pkg::*;

    logic  valid;
    logic  ready;
    char_t out_byte;
    logic  is_last;

    modport source (output valid, out_byte, is_last, input ready);
    modport sink   (input valid, out_byte, is_last, output ready);
endinterface

interface sirt_cfg_if;
    import sirt_pkg::*;

    logic   valid;
    logic   ready;
    count_t symbol_count;

    modport source (output valid, symbol_count, input ready);
    modport sink   (input valid, symbol_count, output ready);
endinterface

/* rtl/sirt_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data
module sirt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/sirt_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the radix text converter
module sirt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  sirt_pkg::sirt_stat_t st,
    output sirt_pkg::sirt_cmd_t  cmd
);
    import sirt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CHECK  = 7'b0000010,
        ST_DIVIDE = 7'b0000100,
        ST_SIGN   = 7'b0001000,
        ST_POP    = 7'b0010000,
        ST_FETCH  = 7'b0100000,
        ST_SHOW   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new word only between conversions
    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_CONVERT)
                    begin
                        cmd.start = 1'b1;
                        if (st.range_ok)
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                cmd.check_en = 1'b1;
                if (st.chk_done)
                begin
                    state_next = st.base_ok ? ST_DIVIDE : ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_en = 1'b1;
                if (st.digit_done && st.quot_zero)
                begin
                    state_next = st.neg ? ST_SIGN : ST_POP;
                end
            end
            ST_SIGN:
            begin
                if (st.out_free)
                begin
                    cmd.sign_load = 1'b1;
                    state_next    = ST_POP;
                end
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (st.out_free)
                begin
                    cmd.show_load = 1'b1;
                    state_next    = st.sp_zero ? ST_IDLE : ST_POP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/sirt_dp.sv */
`timescale 1ns / 1ps
// Datapath: symbol table, base check, shared divider, digit stack, output word
`include "assert_macros.svh"
module sirt_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sirt_pkg::sirt_cmd_t   cmd,
    output sirt_pkg::sirt_stat_t  st,
    input  sirt_pkg::sym_idx_t    symbol_index,
    input  sirt_pkg::char_t       symbol_byte,
    input  logic signed [sirt_pkg::VALUE_BITS-1:0] value,
    sirt_cfg_if.sink              cfg,
    sirt_rsp_if.source            rsp
);
    import sirt_pkg::*;

    count_t                count_reg;
    logic                  neg_reg, neg_next;
    value_t                mag_reg, mag_next;
    count_t                rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [SP_W-1:0]       sp_reg, sp_next;
    count_t                idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic                  bad_reg, bad_next;
    logic [SEEN_W-1:0]     seen_reg, seen_next;
    logic                  out_valid_reg, out_valid_next;
    char_t                 out_byte_reg, out_byte_next;
    logic                  is_last_reg, is_last_next;

    count_t                div_r;
    value_t                div_m;
    logic [SP_W-1:0]       sp_dec;
    char_t                 sym_rdata;
    logic [DIGIT_W-1:0]    stk_rdata;
    sym_idx_t              sym_raddr;
    logic                  out_free;

    // Configuration register is always writable
    assign cfg.ready = 1'b1;

    // Four restoring division steps a cycle: remainder and quotient in place
    always_comb
    begin
        div_r = rem_reg;
        div_m = mag_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            div_r = {div_r[COUNT_W-2:0], div_m[VALUE_BITS-1]};
            div_m = {div_m[VALUE_BITS-2:0], 1'b0};
            if (div_r >= count_reg)
            begin
                div_r    = div_r - count_reg;
                div_m[0] = 1'b1;
            end
        end
    end

    assign sp_dec   = sp_reg - 1'b1;
    assign out_free = !out_valid_reg || rsp.ready;

    // Symbol table: written by load words, read by the check and the emitter
    assign sym_raddr = cmd.fetch ? stk_rdata : idx_reg[SYM_AW-1:0];

    sirt_ram #(
        .DATA_W (CHAR_W),
        .DEPTH  (MAX_SYMBOLS)
    ) u_sym_ram (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (symbol_index),
        .wdata (symbol_byte),
        .re    (cmd.check_en || cmd.fetch),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

    // Digit stack: pushed least significant first, popped for output
    sirt_ram #(
        .DATA_W (DIGIT_W),
        .DEPTH  (VALUE_BITS)
    ) u_stk_ram (
        .clk   (clk),
        .we    (cmd.div_en && st.digit_done),
        .waddr (sp_reg[STACK_AW-1:0]),
        .wdata (div_r[DIGIT_W-1:0]),
        .re    (cmd.pop),
        .raddr (sp_dec[STACK_AW-1:0]),
        .rdata (stk_rdata)
    );

    // Status towards the controller
    always_comb
    begin
        st.range_ok   = (count_reg >= COUNT_W'(2)) && (count_reg <= COUNT_W'(MAX_SYMBOLS));
        st.chk_done   = (idx_reg == count_reg) && !pend_reg;
        st.base_ok    = !bad_reg;
        st.digit_done = (step_reg == STEP_W'(DIV_STEPS - 1));
        st.quot_zero  = (div_m == '0);
        st.neg        = neg_reg;
        st.sp_zero    = (sp_reg == '0);
        st.out_free   = out_free;
    end

    // Next values of the working registers
    always_comb
    begin
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        sp_next       = sp_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        bad_next      = bad_reg;
        seen_next     = seen_reg;
        out_byte_next = out_byte_reg;
        is_last_next  = is_last_reg;

        // Capture the magnitude and clear the check and stack state
        if (cmd.start)
        begin
            neg_next  = value[VALUE_BITS-1];
            mag_next  = value[VALUE_BITS-1] ? (~$unsigned(value) + VALUE_BITS'(1))
                                            : $unsigned(value);
            rem_next  = '0;
            step_next = '0;
            sp_next   = '0;
            idx_next  = '0;
            pend_next = 1'b0;
            bad_next  = 1'b0;
            seen_next = '0;
        end

        // Scan one symbol a cycle: reject separators and repeats
        if (cmd.check_en)
        begin
            pend_next = (idx_reg < count_reg);
            if (idx_reg < count_reg)
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (pend_reg)
            begin
                if (bad_symbol(sym_rdata) || seen_reg[sym_rdata])
                begin
                    bad_next = 1'b1;
                end
                seen_next[sym_rdata] = 1'b1;
            end
        end

        // Advance the divider; push a digit after the last step
        if (cmd.div_en)
        begin
            mag_next = div_m;
            if (st.digit_done)
            begin
                step_next = '0;
                rem_next  = '0;
                sp_next   = sp_reg + 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
                rem_next  = div_r;
            end
        end

        if (cmd.pop)
        begin
            sp_next = sp_dec;
        end

        // Load the output word
        if (cmd.sign_load)
        begin
            out_byte_next = CH_MINUS;
            is_last_next  = 1'b0;
        end
        if (cmd.show_load)
        begin
            out_byte_next = sym_rdata;
            is_last_next  = (sp_reg == '0);
        end
    end

    assign out_valid_next = (out_valid_reg && !rsp.ready) || cmd.sign_load || cmd.show_load;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                count_reg <= cfg.symbol_count;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        sp_reg       <= sp_next;
        idx_reg      <= idx_next;
        pend_reg     <= pend_next;
        bad_reg      <= bad_next;
        seen_reg     <= seen_next;
        out_byte_reg <= out_byte_next;
        is_last_reg  <= is_last_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_byte = out_byte_reg;
    assign rsp.is_last  = is_last_reg;

    `SIRT_ASSERT_IMP(a_stack_bound, clk, rst_n, cmd.div_en && st.digit_done, sp_reg < SP_W'(VALUE_BITS), "digit stack overflow")
    `SIRT_ASSERT_IMP(a_rem_below_radix, clk, rst_n, cmd.div_en, rem_reg < count_reg, "remainder not below radix")
    `SIRT_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.sign_load || cmd.show_load, !out_valid_reg || rsp.ready, "output word overwritten")

endmodule

/* rtl/signed_int_to_radix_text.sv */
`timescale 1ns / 1ps
// Top level of the signed integer to radix text converter
//
//  channel | direction | payload                                  | moves
//  req     | in        | cmd, symbol_index, symbol_byte, value    | load or convert word
//  rsp     | out       | out_byte, is_last                        | one text character
//  cfg     | in        | symbol_count                             | radix register write
//
// A load word writes one symbol table entry. A convert word is accepted, then the
// base check scans the symbol table (one table read a cycle), the shared divider
// forms each digit (four quotient bits a cycle), and each character pops the digit
// stack, looks up the symbol and loads the output register; a sign goes out first.
// rsp stalls hold the output register and the sequencer; req is taken only between
// conversions. Reset clears the sequencer, the output valid and sets the radix to 10.
module signed_int_to_radix_text (
    input  logic       clk,
    input  logic       rst_n,
    sirt_req_if.sink   req,
    sirt_rsp_if.source rsp,
    sirt_cfg_if.sink   cfg
);
    import sirt_pkg::*;

    sirt_cmd_t  cmd;
    sirt_stat_t st;

    // Sequencer
    sirt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.cmd),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath
    sirt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .symbol_index (req.symbol_index),
        .symbol_byte  (req.symbol_byte),
        .value        (req.value),
        .cfg          (cfg),
        .rsp          (rsp)
    );

endmodule
